// File: design/zero_run_length_encoder_defines.svh
// Assertion macros shared by the checker of the zero run-length encoder.
// No dependencies; included by the files that hold concurrent assertions.
`ifndef ZERO_RUN_LENGTH_ENCODER_DEFINES_SVH
`define ZERO_RUN_LENGTH_ENCODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define ZRLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zrle assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ZRLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zrle assertion failed");

`endif

// File: design/zrle_pkg.sv
// Package of the zero run-length encoder: payload and command types, constants
// and the leading-one search. No dependencies.
`timescale 1ns / 1ps

package zrle_pkg;

    localparam int RUN_W       = 16;
    localparam int BIT_W       = $clog2(RUN_W);
    localparam int RUN_MAX     = (1 << RUN_W) - 1;
    localparam int MAX_RUN     = 65535;
    localparam int LIMIT_INT   = (MAX_RUN < RUN_MAX) ? MAX_RUN : RUN_MAX;
    localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(LIMIT_INT);

    localparam logic [7:0] ESC_MIN  = 8'hFE;
    localparam logic [7:0] ESC_BYTE = 8'hFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       block_end;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_item;
    } t_out;

    typedef struct packed {
        logic [RUN_W-1:0] run;
        logic [BIT_W-1:0] nbits;
        logic             has_lit;
        logic [7:0]       lit;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    typedef struct packed {
        logic empty;
        logic full;
        t_cmd cmd;
    } t_qstat;

    // Position of the most significant set bit; zero for values below two.
    function automatic logic [BIT_W-1:0] msb_index(input logic [RUN_W-1:0] c);
        logic [BIT_W-1:0] top;
        top = '0;
        for (int i = 1; i < RUN_W; i++) begin
            if (c[i]) begin
                top = BIT_W'(i);
            end
        end
        return top;
    endfunction

endpackage

// File: design/zero_run_length_encoder.sv
// Zero run-length encoder. A byte that only extends a zero run updates the run count.
// Any other byte is queued; the back stage takes the command into its command register,
// then emits run bits and literal bytes. The two-entry queue lets input run ahead.
// The output stage emits one byte per cycle unless i_ready stalls it or it is idle.
// Reset is synchronous and active low; it empties the queue and sets the run count to one.
`timescale 1ns / 1ps

module zero_run_length_encoder
    import zrle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_push  w_push;
    t_qstat w_qstat;
    logic   w_pop;

    zrle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_data   (i_data),
        .i_q_full (w_qstat.full),
        .o_push   (w_push)
    );

    zrle_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_stat  (w_qstat)
    );

    zrle_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (w_qstat),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

// File: design/zrle_fifo.sv
// Short command queue between the classifying front and the serializing back.
// Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_fifo
    import zrle_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_qstat o_stat
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_push, w_pop;

    always_comb begin
        w_push = i_push.valid && (r_cnt != QCNT_W'(QUEUE_DEPTH));
        w_pop  = i_pop && (r_cnt != '0);
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + QPTR_W'(1);
        end
        if (w_pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

    always_comb begin
        o_stat.empty = (r_cnt == '0);
        o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
        o_stat.cmd   = r_mem[r_rptr];
    end

endmodule

// File: design/zrle_front.sv
// Input side of the encoder: accepts bytes, keeps the pending zero-run count
// and queues a flush or literal command. Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_front
    import zrle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_in   i_data,
    input  logic  i_q_full,
    output t_push o_push
);

    logic [RUN_W-1:0] r_count, n_count;
    logic [RUN_W-1:0] w_inc, w_run;
    logic             w_zero, w_flush, w_take;

    always_comb begin
        o_ready = !i_q_full;
        w_take  = i_valid && o_ready;
        w_zero  = (i_data.in_byte == 8'd0);
        w_inc   = r_count + RUN_W'(1);
        w_flush = !w_zero || i_data.block_end || (w_inc >= RUN_LIMIT);
        w_run   = w_zero ? w_inc : r_count;

        o_push.valid       = w_take && w_flush;
        o_push.cmd.run     = w_run;
        o_push.cmd.nbits   = msb_index(w_run);
        o_push.cmd.has_lit = !w_zero;
        o_push.cmd.lit     = i_data.in_byte;

        n_count = r_count;
        if (w_take) begin
            n_count = w_flush ? RUN_W'(1) : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= RUN_W'(1);
        end else begin
            r_count <= n_count;
        end
    end

endmodule

// File: design/zrle_back.sv
// Output side of the encoder: serializes run bits, literals and escapes from
// queued commands into a registered output stage. Depends on zrle_pkg.
`timescale 1ns / 1ps

module zrle_back
    import zrle_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qstat i_q,
    output logic   o_pop,
    output logic   o_valid,
    input  logic   i_ready,
    output t_out   o_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_LIT  = 2'd2;
    localparam logic [1:0] S_ESC  = 2'd3;

    logic [1:0]       r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    logic [BIT_W-1:0] r_k, n_k;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;
    logic             w_slot, w_emit;

    always_comb begin
        w_slot      = !r_out_valid || i_ready;
        w_emit      = 1'b0;
        o_pop       = 1'b0;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_k         = r_k;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q.empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q.cmd;
                    n_k     = i_q.cmd.nbits - BIT_W'(1);
                    n_state = (i_q.cmd.nbits != '0) ? S_RUN : S_LIT;
                end
            end
            S_RUN: begin
                if (w_slot) begin
                    w_emit             = 1'b1;
                    n_out.out_byte     = {7'd0, r_cmd.run[r_k]};
                    n_out.last_of_item = (r_k == '0) && !r_cmd.has_lit;
                    if (r_k == '0) begin
                        n_state = r_cmd.has_lit ? S_LIT : S_IDLE;
                    end else begin
                        n_k = r_k - BIT_W'(1);
                    end
                end
            end
            S_LIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    if (r_cmd.lit >= ESC_MIN) begin
                        n_out.out_byte     = ESC_BYTE;
                        n_out.last_of_item = 1'b0;
                        n_state            = S_ESC;
                    end else begin
                        n_out.out_byte     = r_cmd.lit + 8'd1;
                        n_out.last_of_item = 1'b1;
                        n_state            = S_IDLE;
                    end
                end
            end
            S_ESC: begin
                if (w_slot) begin
                    w_emit             = 1'b1;
                    n_out.out_byte     = r_cmd.lit - ESC_MIN;
                    n_out.last_of_item = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_emit ? 1'b1 : (r_out_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_k   <= n_k;
        r_out <= n_out;
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

// File: design/zrle_checker.sv
// Port-level checks of the zero run-length encoder, bound to the top level.
// Depends on zrle_pkg and zero_run_length_encoder_defines.svh.
`timescale 1ns / 1ps
`include "zero_run_length_encoder_defines.svh"

module zrle_checker
    import zrle_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input t_in  i_data,
    input logic o_valid,
    input logic i_ready,
    input t_out o_data
);

    logic w_out_esc;
    logic w_out_lit;

    assign w_out_esc = (o_data.out_byte == ESC_BYTE);
    assign w_out_lit = (o_data.out_byte > 8'd1) && !w_out_esc;

    // A stalled input transfer keeps its byte and flag.
    `ZRLE_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(i_data))

    // A stalled output transfer keeps its byte and flag.
    `ZRLE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))

    // An escape byte never closes its item, since its selector byte follows.
    `ZRLE_ASSERT_NOW(a_esc_not_last, i_clk, i_rst_n, o_valid && w_out_esc, !o_data.last_of_item)

    // A plain literal always closes its item.
    `ZRLE_ASSERT_NOW(a_lit_last, i_clk, i_rst_n, o_valid && w_out_lit, o_data.last_of_item)

endmodule

bind zero_run_length_encoder zrle_checker u_zrle_checker (.*);
